@@ hw/rtl/goldbach_pair_counter_core_defines.svh @@
// Assertion macros for the goldbach pair counter core.
`ifndef GOLDBACH_PAIR_COUNTER_CORE_DEFINES_SVH
`define GOLDBACH_PAIR_COUNTER_CORE_DEFINES_SVH

// Check a property at every rising clock edge outside reset.
`define GPC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition implies another one in the next cycle.
`define GPC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/gpc_pkg.sv @@
// Package with shared types and constants of the goldbach pair counter.
`timescale 1ns / 1ps
`default_nettype none
package gpc_pkg;

  localparam int ValueW     = 13;
  localparam int CountW     = 12;
  localparam int DivW       = 7;   // trial divisors stay below 128
  localparam int BitCntW    = 4;   // counts dividend bits 0..ValueW-1
  localparam int ValueLimit = 8192;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_LOOP,
    S_CHECK,
    S_DIV,
    S_REM,
    S_FIN
  } state_e;

  typedef struct packed {
    logic load;       // capture value, i = 2, count = 0
    logic test_lo;    // start primality test of i
    logic test_hi;    // start primality test of value - i
    logic div_start;  // start n mod d
    logic div_step;   // one restoring division step
    logic d_inc;      // next trial divisor
    logic i_inc;      // next candidate
    logic count_inc;  // one more prime pair
    logic out_load;   // move count into the output register
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic i_gt_half;
    logic n_lt2;
    logic d_sq_gt_n;
    logic div_last;
    logic rem_zero;
    logic phase_hi;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/goldbach_pair_counter_core.sv @@
// Top level of the goldbach pair counter: controller, datapath and checks.
// A value up to 2 goes straight to the result; else each candidate and, if it is prime, value - i are tested
// by trial division, each trial divisor taking a check, 13 serial division steps and a remainder step.
// Throughput: one item at a time; the next beat is taken once the count is in the output register.
// A finished count waits in the output register while the next item is already being worked on.
// Reset: asynchronous, active low; clears the state machine and output valid, drops any item.
`timescale 1ns / 1ps
`default_nettype none
`include "goldbach_pair_counter_core_defines.svh"
module goldbach_pair_counter_core #(
  parameter int ValueLimit = gpc_pkg::ValueLimit
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [gpc_pkg::ValueW-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gpc_pkg::CountW-1:0]  pair_count_o
);
  import gpc_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  cmd_t cmd;
  sts_t sts;

  // Sequencer: walks candidates i = 2..value/2, tests i and value - i by trial
  // division, and hands the final count to the output register.
  gpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: holds the value, candidate, divisor, serial remainder and count,
  // plus the output register that decouples the result beat from new work.
  gpc_datapath #(
    .ValueLimit (ValueLimit)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      (value_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .pair_count_o (pair_count_o)
  );

  // After taking a beat the block is busy in the next cycle.
  `GPC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o,
                   "input taken while previous item still in progress")

  // A count for 13-bit values never exceeds 2048.
  `GPC_ASSERT(a_count_range, !out_valid_o || (pair_count_o <= 12'd2048),
              "pair count out of range")

  // A new result shows up exactly when the sequencer returns to idle.
  `GPC_ASSERT(a_result_frees_input, !$rose(out_valid_o) || in_ready_o,
              "result loaded without releasing the input side")

endmodule
`default_nettype wire

@@ hw/rtl/gpc_datapath.sv @@
// Datapath: candidate and divisor registers, serial divider, pair count, output register.
`timescale 1ns / 1ps
`default_nettype none
module gpc_datapath #(
  parameter int ValueLimit = gpc_pkg::ValueLimit
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gpc_pkg::cmd_t                cmd_i,
  output gpc_pkg::sts_t                sts_o,
  input  logic [gpc_pkg::ValueW-1:0]   value_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [gpc_pkg::CountW-1:0]   pair_count_o
);
  import gpc_pkg::*;

  logic [ValueW-1:0]  value_q, i_q, n_q, sh_q;
  logic [ValueW-1:0]  i_d, n_d, sh_d, half;
  logic [DivW-1:0]    d_q, d_d, rem_q, rem_d;
  logic [DivW:0]      trial;
  logic [2*DivW-1:0]  d_sq;
  logic [BitCntW-1:0] bit_q, bit_d;
  logic [CountW-1:0]  count_q, count_d, out_q;
  logic               phase_q, phase_d, out_valid_q;

  assign half  = value_q >> 1;
  assign d_sq  = {{DivW{1'b0}}, d_q} * {{DivW{1'b0}}, d_q};
  assign trial = {rem_q, sh_q[ValueW-1]};

  always_comb begin
    i_d     = i_q;
    n_d     = n_q;
    d_d     = d_q;
    phase_d = phase_q;
    count_d = count_q;
    sh_d    = sh_q;
    rem_d   = rem_q;
    bit_d   = bit_q;
    if (cmd_i.load) begin
      i_d     = ValueW'(2);
      count_d = '0;
    end
    if (cmd_i.i_inc) begin
      i_d = i_q + ValueW'(1);
    end
    if (cmd_i.test_lo) begin
      n_d     = i_q;
      d_d     = DivW'(2);
      phase_d = 1'b0;
    end
    if (cmd_i.test_hi) begin
      n_d     = value_q - i_q;
      d_d     = DivW'(2);
      phase_d = 1'b1;
    end
    if (cmd_i.d_inc) begin
      d_d = d_q + DivW'(1);
    end
    if (cmd_i.count_inc && count_q != CountMax) begin
      count_d = count_q + CountW'(1);
    end
    if (cmd_i.div_start) begin
      sh_d  = n_q;
      rem_d = '0;
      bit_d = '0;
    end
    if (cmd_i.div_step) begin
      // restoring step: shift in next dividend bit, subtract if it fits
      if (trial >= {1'b0, d_q}) begin
        rem_d = DivW'(trial - {1'b0, d_q});
      end else begin
        rem_d = trial[DivW-1:0];
      end
      sh_d  = sh_q << 1;
      bit_d = bit_q + BitCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= value_i;
    end
    i_q     <= i_d;
    n_q     <= n_d;
    d_q     <= d_d;
    phase_q <= phase_d;
    count_q <= count_d;
    sh_q    <= sh_d;
    rem_q   <= rem_d;
    bit_q   <= bit_d;
    if (cmd_i.out_load) begin
      out_q <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.in_range  = (value_q > ValueW'(2)) && (32'(value_q) < ValueLimit);
  assign sts_o.i_gt_half = i_q > half;
  assign sts_o.n_lt2     = n_q < ValueW'(2);
  assign sts_o.d_sq_gt_n = d_sq > {1'b0, n_q};
  assign sts_o.div_last  = bit_q == BitCntW'(ValueW - 1);
  assign sts_o.rem_zero  = rem_q == '0;
  assign sts_o.phase_hi  = phase_q;
  assign sts_o.out_busy  = out_valid_q;

  assign out_valid_o  = out_valid_q;
  assign pair_count_o = out_q;

endmodule
`default_nettype wire

@@ hw/rtl/gpc_ctrl.sv @@
// Controller state machine: sequences candidates, trial divisors and division steps.
`timescale 1ns / 1ps
`default_nettype none
module gpc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gpc_pkg::sts_t sts_i,
  output gpc_pkg::cmd_t cmd_o
);
  import gpc_pkg::*;

  state_e state_q, state_d;
  logic   is_prime;

  assign is_prime = !sts_i.n_lt2 && sts_i.d_sq_gt_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SETUP;
      end
      S_SETUP: begin
        state_d = sts_i.in_range ? S_LOOP : S_FIN;
      end
      S_LOOP: begin
        state_d = sts_i.i_gt_half ? S_FIN : S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.n_lt2) begin
          state_d = S_LOOP;
        end else if (is_prime) begin
          state_d = sts_i.phase_hi ? S_LOOP : S_CHECK;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_last) state_d = S_REM;
      end
      S_REM: begin
        state_d = sts_i.rem_zero ? S_LOOP : S_CHECK;
      end
      S_FIN: begin
        if (!sts_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      S_SETUP: ;
      S_LOOP: begin
        cmd_o.test_lo = !sts_i.i_gt_half;
      end
      S_CHECK: begin
        if (sts_i.n_lt2) begin
          cmd_o.i_inc = 1'b1;
        end else if (is_prime) begin
          if (sts_i.phase_hi) begin
            cmd_o.count_inc = 1'b1;
            cmd_o.i_inc     = 1'b1;
          end else begin
            cmd_o.test_hi = 1'b1;
          end
        end else begin
          cmd_o.div_start = 1'b1;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      S_REM: begin
        cmd_o.i_inc = sts_i.rem_zero;
        cmd_o.d_inc = !sts_i.rem_zero;
      end
      S_FIN: begin
        cmd_o.out_load = !sts_i.out_busy;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
